### rtl/keyed_typed_message_queues_macros.svh
// assertion macros for the message queue engine
`ifndef KEYED_TYPED_MESSAGE_QUEUES_MACROS_SVH
`define KEYED_TYPED_MESSAGE_QUEUES_MACROS_SVH
`ifndef SYNTHESIS
`define KTMQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KTMQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTMQ_ASSERT(label, clk, rst_n, prop, msg)
`define KTMQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/ktmq_pkg.sv
package ktmq_pkg;
  localparam int unsigned NumQueuesDefault  = 8;
  localparam int unsigned QueueDepthDefault = 16;

  localparam logic [15:0] VolumeLimitReset = 16'd4096;
  localparam logic [7:0]  EntryBytesReset  = 8'd64;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgVolumeLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEntryBytes  = 1'b1;

  typedef enum logic [2:0] {
    OpCreate  = 3'd0,
    OpRemove  = 3'd1,
    OpSend    = 3'd2,
    OpReceive = 3'd3,
    OpExists  = 3'd4,
    OpIsFull  = 3'd5,
    OpIsEmpty = 3'd6,
    OpNoQueue = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoQueue = 2'd1,
    StNoMatch = 2'd2,
    StNoRoom  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] queue_key;
    logic signed [31:0] msg_type;
    logic [31:0]        payload;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               answer;
    logic signed [31:0] key_out;
    logic signed [31:0] type_out;
    logic [31:0]        payload_out;
  } rsp_t;

  // selector match: zero any, positive exact, negative up to magnitude
  function automatic logic type_match(logic signed [31:0] sel, logic signed [31:0] t);
    logic signed [32:0] mag;
    mag = -{sel[31], sel};
    if (sel == 32'sd0) return 1'b1;
    if (!sel[31]) return t == sel;
    return $signed({t[31], t}) <= mag;
  endfunction
endpackage

### rtl/ktmq_if.sv
interface ktmq_req_if import ktmq_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0]         op;
  logic signed [31:0] queue_key;
  logic signed [31:0] msg_type;
  logic [31:0]        payload;
  modport source (output valid, op, queue_key, msg_type, payload, input ready);
  modport sink (input valid, op, queue_key, msg_type, payload, output ready);
endinterface

interface ktmq_rsp_if import ktmq_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0]         status;
  logic               answer;
  logic signed [31:0] key_out;
  logic signed [31:0] type_out;
  logic [31:0]        payload_out;
  modport source (output valid, status, answer, key_out, type_out, payload_out,
                  input ready);
  modport sink (input valid, status, answer, key_out, type_out, payload_out,
                output ready);
endinterface

### rtl/ktmq_ram.sv
module ktmq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0]      waddr_i,
  input  logic [Width-1:0]                                wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0]      raddr_i,
  output logic [Width-1:0]                                rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/keyed_typed_message_queues.sv
// Keyed typed message queues: NUM_QUEUES keyed mailboxes of QUEUE_DEPTH
// messages each, one operation word in and one result word out. Keys and
// counts live in flip-flops; the key of a word is matched against every slot
// as the word is accepted. Messages live in two single-port-write,
// registered-read RAMs (type and body) of NUM_QUEUES*QUEUE_DEPTH entries each.
// Receive reads the queue one entry a cycle up to the first match, then moves
// each later entry down one place while reading the next, so every entry is
// read once. A receive result is registered as soon as the match is seen and
// may be taken while the compaction runs on. One operation is worked at a
// time; the next word is taken only once the result has been taken.
module keyed_typed_message_queues
  import ktmq_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = NumQueuesDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ktmq_req_if.sink            req,
  ktmq_rsp_if.source          rsp
);
`include "keyed_typed_message_queues_macros.svh"

  localparam int unsigned SlotW  = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MemD   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AddrW  = $clog2(MemD) > 0 ? $clog2(MemD) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  // one-hot controller states
  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SDec   = 6'b000010,
    SScan  = 6'b000100,
    SShift = 6'b001000,
    SWr    = 6'b010000,
    SOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] vol_q;
  logic [7:0]  ebytes_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q    <= VolumeLimitReset;
      ebytes_q <= EntryBytesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVolumeLimit: vol_q    <= cfg_data_i;
        CfgEntryBytes:  ebytes_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // slot table
  logic [NUM_QUEUES-1:0] used_q;
  logic [31:0]           key_q [NUM_QUEUES];
  logic [CntW-1:0]       cnt_q [NUM_QUEUES];

  req_t req_q;
  rsp_t rsp_q;
  logic rsp_valid_q;

  // lookup of the incoming word, registered at accept
  logic             hit_q, free_q;
  logic [SlotW-1:0] slot_q, fslot_q;
  logic             hit_c, free_c;
  logic [SlotW-1:0] slot_c, fslot_c;
  always_comb begin
    hit_c = 1'b0; slot_c = '0; free_c = 1'b0; fslot_c = '0;
    for (int s = NUM_QUEUES - 1; s >= 0; s--) begin
      if (used_q[s] && key_q[s] == req.queue_key) begin
        hit_c = 1'b1; slot_c = SlotW'(s);
      end
      if (!used_q[s]) begin
        free_c = 1'b1; fslot_c = SlotW'(s);
      end
    end
  end

  logic [CntW-1:0] n_c;
  logic [23:0]     vol_use_c;
  logic            full_c;
  assign n_c       = cnt_q[slot_q];
  assign vol_use_c = 24'(n_c) * 24'(ebytes_q);
  assign full_c    = (n_c >= DepthC) || (vol_use_c >= 24'(vol_q));

  // message RAMs
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wtype, wbody, rtype, rbody;
  ktmq_ram #(.Width(32), .Depth(MemD)) u_type_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wtype),
    .raddr_i(raddr), .rdata_o(rtype));
  ktmq_ram #(.Width(32), .Depth(MemD)) u_body_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wbody),
    .raddr_i(raddr), .rdata_o(rbody));

  // scan and compaction pointers: rd_q is the entry whose data arrives now
  logic [CntW-1:0] rd_q, rd_d;
  logic            rd_vld_q, rd_vld_d;

  function automatic logic [AddrW-1:0] addr_of(logic [SlotW-1:0] s, logic [CntW-1:0] e);
    logic [AddrW+CntW:0] a;
    a = (AddrW+CntW+1)'(s) * (AddrW+CntW+1)'(QUEUE_DEPTH) + (AddrW+CntW+1)'(e);
    return a[AddrW-1:0];
  endfunction

  logic in_fire, out_fire;
  assign req.ready   = state_q == SIdle;
  assign in_fire     = req.valid && req.ready;
  assign out_fire    = rsp_valid_q && rsp.ready;

  logic            set_rsp;
  rsp_t            rsp_d;
  logic            cnt_we, used_set, used_clr;
  logic [CntW-1:0] cnt_wd;
  logic [SlotW-1:0] cnt_slot;

  always_comb begin
    state_d  = state_q;
    rd_d     = rd_q;
    rd_vld_d = 1'b0;
    we = 1'b0; waddr = addr_of(slot_q, rd_q); wtype = rtype; wbody = rbody;
    raddr = addr_of(slot_q, rd_q);
    set_rsp = 1'b0; rsp_d = '0;
    cnt_we = 1'b0; cnt_wd = '0; cnt_slot = slot_q; used_set = 1'b0; used_clr = 1'b0;
    unique case (state_q)
      SIdle: if (in_fire) state_d = SDec;
      SDec: begin
        state_d = SOut;
        unique case (op_e'(req_q.op))
          OpCreate: begin
            if (hit_q) rsp_d.key_out = req_q.queue_key;
            else if (free_q) begin
              rsp_d.key_out = req_q.queue_key;
              used_set = 1'b1; cnt_we = 1'b1; cnt_slot = fslot_q;
            end else rsp_d.status = StNoRoom;
          end
          OpRemove: begin
            if (hit_q) begin used_clr = 1'b1; cnt_we = 1'b1; end
            else rsp_d.status = StNoQueue;
          end
          OpSend: begin
            if (!hit_q) rsp_d.status = StNoQueue;
            else if (full_c) rsp_d.status = StNoRoom;
            else begin
              we = 1'b1; waddr = addr_of(slot_q, n_c);
              wtype = req_q.msg_type; wbody = req_q.payload;
              cnt_we = 1'b1; cnt_wd = n_c + 1'b1;
              state_d = SWr;
            end
          end
          OpReceive: begin
            if (!hit_q) rsp_d.status = StNoQueue;
            else if (n_c == '0) rsp_d.status = StNoMatch;
            else begin
              raddr = addr_of(slot_q, '0);
              rd_d = '0; rd_vld_d = 1'b1;
              state_d = SScan;
            end
          end
          OpExists: begin
            if (hit_q) rsp_d.key_out = req_q.queue_key;
            else rsp_d.status = StNoQueue;
          end
          OpIsFull: begin
            if (hit_q) rsp_d.answer = full_c;
            else rsp_d.status = StNoQueue;
          end
          OpIsEmpty: begin
            if (hit_q) rsp_d.answer = n_c == '0;
            else rsp_d.status = StNoQueue;
          end
          OpNoQueue: rsp_d.answer = !hit_q;
          default: ;
        endcase
        if (state_d == SOut) set_rsp = 1'b1;
      end
      SScan: begin
        if (rd_vld_q && type_match(req_q.msg_type, rtype)) begin
          set_rsp = 1'b1;
          rsp_d.type_out = rtype; rsp_d.payload_out = rbody;
          cnt_we = 1'b1; cnt_wd = n_c - 1'b1;
          // start reading the entry after the match
          rd_d = rd_q + 1'b1;
          raddr = addr_of(slot_q, rd_d);
          rd_vld_d = 1'b1;
          state_d = (rd_d >= n_c) ? SOut : SShift;
        end else if (rd_q + 1'b1 >= n_c) begin
          set_rsp = 1'b1; rsp_d.status = StNoMatch;
          state_d = SOut;
        end else begin
          rd_d = rd_q + 1'b1;
          raddr = addr_of(slot_q, rd_d);
          rd_vld_d = 1'b1;
        end
      end
      SShift: begin
        // count already lowered: entry rd_q moves to rd_q-1
        we = 1'b1; waddr = addr_of(slot_q, rd_q - 1'b1);
        rd_d = rd_q + 1'b1;
        raddr = addr_of(slot_q, rd_d);
        rd_vld_d = 1'b1;
        if (rd_q >= n_c) state_d = SOut;
      end
      SWr: begin
        set_rsp = 1'b1;
        state_d = SOut;
      end
      SOut: if (!rsp_valid_q || out_fire) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      for (int s = 0; s < NUM_QUEUES; s++) cnt_q[s] <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      if (cnt_we) cnt_q[cnt_slot] <= cnt_wd;
      if (used_set) used_q[fslot_q] <= 1'b1;
      if (used_clr) used_q[slot_q] <= 1'b0;
      if (set_rsp) rsp_valid_q <= 1'b1;
      else if (out_fire) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_t'({req.op, req.queue_key, req.msg_type, req.payload});
      hit_q <= hit_c; slot_q <= slot_c; free_q <= free_c; fslot_q <= fslot_c;
    end
    if (used_set) key_q[fslot_q] <= req_q.queue_key;
    if (set_rsp) rsp_q <= rsp_d;
    rd_q <= rd_d;
  end

  assign rsp.valid       = rsp_valid_q && state_q != SDec;
  assign rsp.status      = rsp_q.status;
  assign rsp.answer      = rsp_q.answer;
  assign rsp.key_out     = rsp_q.key_out;
  assign rsp.type_out    = rsp_q.type_out;
  assign rsp.payload_out = rsp_q.payload_out;

  `KTMQ_ASSERT(a_one_op, clk_i, rst_ni, in_fire |=> state_q == SDec, "accept must decode")
  `KTMQ_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_we |-> cnt_wd <= DepthC, "count over depth")
  `KTMQ_ASSERT(a_no_accept_busy, clk_i, rst_ni, state_q != SIdle |-> !req.ready, "busy accept")
endmodule

### test/testbench.sv
module testbench;
  import ktmq_pkg::*;

  localparam int unsigned Slots = NumQueuesDefault;
  localparam int unsigned Depth = QueueDepthDefault;
  // longest receive at full depth plus the output register
  localparam int unsigned DrainCycles = 2 * Depth + 20;
  localparam longint unsigned CycleLimit = 400000;

  // one directed row: the operation word and, where it is obvious, its result
  typedef struct {
    op_e         op;
    logic [31:0] key;
    logic [31:0] sel;
    logic [31:0] body;
    bit          known;
    rsp_t        want;
  } step_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ktmq_req_if req_bus ();
  ktmq_rsp_if rsp_bus ();

  keyed_typed_message_queues DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  // mirror of the mailbox state
  logic [15:0] mb_volume;
  logic [7:0]  mb_entry;
  bit          mb_used [Slots];
  logic [31:0] mb_key  [Slots];
  int unsigned mb_count[Slots];
  logic [31:0] mb_type [Slots][Depth];
  logic [31:0] mb_body [Slots][Depth];

  rsp_t        pending_rsp[$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned receives_hit;
  int unsigned sends_refused;
  bit          calm;          // no idling on either side while set
  longint unsigned cycles;

  logic [31:0] key_pool[10];

  // clock: period 10
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               pending_rsp.size());
      $display("keyed_typed_message_queues regression: fail");
      $finish;
    end
  end

  // result side stalls at random, with a chance of about 7 in 100 per draw, unless calm
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  function automatic int find_queue(logic [31:0] key);
    for (int s = 0; s < Slots; s++) begin
      if (mb_used[s] && mb_key[s] == key) return s;
    end
    return -1;
  endfunction

  function automatic bit queue_is_full(int s);
    longint unsigned vol;
    vol = longint'(mb_count[s]) * longint'(mb_entry);
    return mb_count[s] >= Depth || vol >= longint'(mb_volume);
  endfunction

  // zero takes any, positive exact, negative anything up to its magnitude
  function automatic bit selector_hits(logic [31:0] sel, logic [31:0] t);
    longint ssel;
    longint st;
    ssel = longint'($signed(sel));
    st = longint'($signed(t));
    if (ssel == 0) return 1'b1;
    if (ssel > 0) return st == ssel;
    return st <= -ssel;
  endfunction

  // works out the result of one accepted word and updates the mirror
  function automatic rsp_t mailbox_result(op_e op, logic [31:0] key, logic [31:0] sel,
                                          logic [31:0] body);
    rsp_t r;
    int s;
    int f;
    int hit;
    r = '0;
    s = find_queue(key);
    case (op)
      OpCreate: begin
        if (s >= 0) begin
          r.key_out = key;
        end else begin
          f = -1;
          for (int i = Slots - 1; i >= 0; i--) if (!mb_used[i]) f = i;
          if (f >= 0) begin
            mb_used[f] = 1'b1;
            mb_key[f] = key;
            mb_count[f] = 0;
            r.key_out = key;
          end else begin
            r.status = StNoRoom;
          end
        end
      end
      OpRemove: begin
        if (s >= 0) begin
          mb_used[s] = 1'b0;
          mb_count[s] = 0;
        end else begin
          r.status = StNoQueue;
        end
      end
      OpSend: begin
        if (s < 0) begin
          r.status = StNoQueue;
        end else if (queue_is_full(s)) begin
          r.status = StNoRoom;
          sends_refused++;
        end else begin
          mb_type[s][mb_count[s]] = sel;
          mb_body[s][mb_count[s]] = body;
          mb_count[s]++;
        end
      end
      OpReceive: begin
        if (s < 0) begin
          r.status = StNoQueue;
        end else begin
          hit = -1;
          for (int i = 0; i < mb_count[s]; i++) begin
            if (hit < 0 && selector_hits(sel, mb_type[s][i])) hit = i;
          end
          if (hit < 0) begin
            r.status = StNoMatch;
          end else begin
            r.type_out = mb_type[s][hit];
            r.payload_out = mb_body[s][hit];
            // close the gap, keeping age order
            for (int i = hit; i + 1 < mb_count[s]; i++) begin
              mb_type[s][i] = mb_type[s][i + 1];
              mb_body[s][i] = mb_body[s][i + 1];
            end
            mb_count[s]--;
            receives_hit++;
          end
        end
      end
      OpExists: begin
        if (s >= 0) r.key_out = key;
        else r.status = StNoQueue;
      end
      OpIsFull: begin
        if (s >= 0) r.answer = queue_is_full(s);
        else r.status = StNoQueue;
      end
      OpIsEmpty: begin
        if (s >= 0) r.answer = (mb_count[s] == 0);
        else r.status = StNoQueue;
      end
      default: begin
        r.answer = (s < 0);
      end
    endcase
    return r;
  endfunction

  // result checker: pre-edge sampling of the handshake
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.status = rsp_bus.status;
      got.answer = rsp_bus.answer;
      got.key_out = rsp_bus.key_out;
      got.type_out = rsp_bus.type_out;
      got.payload_out = rsp_bus.payload_out;
      words_checked++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.answer !== want.answer ||
            got.key_out !== want.key_out || got.type_out !== want.type_out ||
            got.payload_out !== want.payload_out) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch: status %0d/%0d answer %0d/%0d key %h/%h",
                     words_checked, want.status, got.status, want.answer, got.answer,
                     want.key_out, got.key_out);
            $display("  type %h/%h payload %h/%h (expected/actual)", want.type_out,
                     got.type_out, want.payload_out, got.payload_out);
          end
        end
      end
    end
  end

  // sends one word, at times after a random gap, and waits for its acceptance
  task automatic send_word(op_e op, logic [31:0] key, logic [31:0] sel,
                           logic [31:0] body, bit known, rsp_t want);
    rsp_t predicted;
    if (!calm && $urandom_range(99) < 7) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.queue_key <= key;
    req_bus.msg_type <= sel;
    req_bus.payload <= body;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predicted = mailbox_result(op, key, sel, body);
    pending_rsp.push_back(known ? want : predicted);
    words_sent++;
  endtask

  // registers are only touched while nothing is in flight
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    req_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgVolumeLimit) mb_volume = data;
    else mb_entry = data[7:0];
  endtask

  function automatic step_t row(op_e op, logic [31:0] key, logic [31:0] sel,
                                logic [31:0] body);
    step_t t;
    t.op = op;
    t.key = key;
    t.sel = sel;
    t.body = body;
    t.known = 1'b0;
    t.want = '0;
    return t;
  endfunction

  function automatic step_t row_known(op_e op, logic [31:0] key, status_e st, bit ans,
                                      logic [31:0] kout);
    step_t t;
    t = row(op, key, 32'd0, 32'd0);
    t.known = 1'b1;
    t.want.status = st;
    t.want.answer = ans;
    t.want.key_out = kout;
    return t;
  endfunction

  function automatic op_e pick_op();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 12) return OpCreate;
    if (w < 17) return OpRemove;
    if (w < 47) return OpSend;
    if (w < 72) return OpReceive;
    if (w < 78) return OpExists;
    if (w < 86) return OpIsFull;
    if (w < 94) return OpIsEmpty;
    return OpNoQueue;
  endfunction

  // mostly a small set of types so receives find something
  function automatic logic [31:0] pick_type();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 70) return 32'($signed($urandom_range(8)) - 4);
    if (w < 78) return 32'h8000_0000;
    if (w < 86) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  initial begin
    step_t steps[$];
    logic [31:0] k;
    int unsigned phase_words;
    rsp_t none;
    none = '0;
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    receives_hit = 0;
    sends_refused = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_bus.valid = 1'b0;
    req_bus.op = OpNoQueue;
    req_bus.queue_key = '0;
    req_bus.msg_type = '0;
    req_bus.payload = '0;
    rsp_bus.ready = 1'b0;
    mb_volume = VolumeLimitReset;
    mb_entry = EntryBytesReset;
    for (int s = 0; s < Slots; s++) begin
      mb_used[s] = 1'b0;
      mb_key[s] = '0;
      mb_count[s] = 0;
    end
    key_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'd1,
                 32'd7, 32'h5555_aaaa, 32'haaaa_5555, 32'd42, 32'hdead_0001};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty engine, key extremes, selector kinds, slot exhaustion
    steps = '{
      row_known(OpNoQueue, 32'd5, StOk, 1'b1, 32'd0),
      row_known(OpExists, 32'd5, StNoQueue, 1'b0, 32'd0),
      row_known(OpSend, 32'd5, StNoQueue, 1'b0, 32'd0),
      row_known(OpReceive, 32'd5, StNoQueue, 1'b0, 32'd0),
      row_known(OpIsFull, 32'd5, StNoQueue, 1'b0, 32'd0),
      row_known(OpIsEmpty, 32'd5, StNoQueue, 1'b0, 32'd0),
      row_known(OpRemove, 32'd5, StNoQueue, 1'b0, 32'd0),
      row_known(OpCreate, 32'h8000_0000, StOk, 1'b0, 32'h8000_0000),
      row_known(OpCreate, 32'h7fff_ffff, StOk, 1'b0, 32'h7fff_ffff),
      row_known(OpIsEmpty, 32'h8000_0000, StOk, 1'b1, 32'd0),
      row(OpSend, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000),
      row(OpSend, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff),
      row(OpSend, 32'h8000_0000, 32'd3, 32'h1234_5678),
      row(OpSend, 32'h8000_0000, 32'd9, 32'h8765_4321),
      row(OpReceive, 32'h8000_0000, 32'd3, 32'd0),          // exact type
      row(OpReceive, 32'h8000_0000, 32'hffff_fff6, 32'd0),  // up to ten, first in age
      row(OpReceive, 32'h8000_0000, 32'd4, 32'd0),          // nothing of that type
      row(OpReceive, 32'h8000_0000, 32'h8000_0000, 32'd0),  // widest magnitude
      row(OpReceive, 32'h8000_0000, 32'd0, 32'd0),          // oldest
      row_known(OpCreate, 32'h7fff_ffff, StOk, 1'b0, 32'h7fff_ffff),  // reuse
      row_known(OpCreate, 32'd0, StOk, 1'b0, 32'd0),
      row(OpCreate, 32'd11, 32'd0, 32'd0),
      row(OpCreate, 32'd12, 32'd0, 32'd0),
      row(OpCreate, 32'd13, 32'd0, 32'd0),
      row(OpCreate, 32'd14, 32'd0, 32'd0),
      row(OpCreate, 32'd15, 32'd0, 32'd0),
      row_known(OpCreate, 32'd16, StNoRoom, 1'b0, 32'd0),   // every slot taken
      row_known(OpExists, 32'h7fff_ffff, StOk, 1'b0, 32'h7fff_ffff)
    };
    foreach (steps[i]) begin
      send_word(steps[i].op, steps[i].key, steps[i].sel, steps[i].body,
                steps[i].known, steps[i].want);
    end

    // fill one queue past its depth, then remove every queue
    for (int i = 0; i <= Depth; i++) begin
      send_word(OpSend, 32'd11, pick_type(), $urandom(), 1'b0, none);
    end
    send_word(OpIsFull, 32'd11, 32'd0, 32'd0, 1'b0, none);
    for (int s = 0; s < Slots; s++) begin
      send_word(OpRemove, s < 3 ? key_pool[s] : 32'd11 + s - 3, 32'd0, 32'd0, 1'b0,
                none);
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgVolumeLimit, 16'd0);      // every queue full
          write_reg(CfgEntryBytes, 8'd1);
        end
        1: begin
          write_reg(CfgVolumeLimit, 16'hffff);   // only depth limits
          write_reg(CfgEntryBytes, 8'd255);
        end
        2: begin
          write_reg(CfgVolumeLimit, 16'd500);    // full at two words
          write_reg(CfgEntryBytes, 8'd255);
        end
        3: begin
          write_reg(CfgVolumeLimit, 16'd6);      // full at six words
          write_reg(CfgEntryBytes, 8'd1);
        end
        default: begin
          write_reg(CfgVolumeLimit, VolumeLimitReset);
          write_reg(CfgEntryBytes, EntryBytesReset);
        end
      endcase
      phase_words = (ph == 0) ? 80 : 180;
      calm = (ph == 2);
      for (int n = 0; n < phase_words; n++) begin
        k = ($urandom_range(99) < 92) ? key_pool[$urandom_range(9)] : $urandom();
        send_word(pick_op(), k, pick_type(), $urandom(), 1'b0, none);
      end
    end
    calm = 1'b0;
    req_bus.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d words sent and %0d results checked over five register settings",
             words_sent, words_checked);
    $display("%0d receives found a message, %0d sends refused, %0d mismatches",
             receives_hit, sends_refused, mismatches);
    if (mismatches == 0) begin
      $display("keyed_typed_message_queues regression: pass");
    end else begin
      $display("keyed_typed_message_queues regression: fail");
    end
    $finish;
  end

endmodule
